// ===== hdl/jlvr_pkg.sv =====
// ----------------------------------------------------------------------------
// jlvr_pkg: shared types and constants of the jerk-limited velocity ramp
// Widths, register indexes and reset values, sequencer states, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package jlvr_pkg;

  // Field widths. Velocities and accelerations are signed, 16 fraction bits.
  localparam int VALUE_W   = 24;
  localparam int LIMIT_W   = VALUE_W - 1;
  localparam int TIME_W    = 16;
  localparam int TIME_FRAC = 16;
  localparam int PROD_W    = VALUE_W + TIME_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [LIMIT_W-1:0]        limit_t;
  typedef logic [TIME_W-1:0]         time_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [PROD_W-1:0]         prod_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_LIN_ACCEL = cfg_idx_t'(0);
  localparam cfg_idx_t REG_LIN_DECEL = cfg_idx_t'(1);
  localparam cfg_idx_t REG_LIN_JERK  = cfg_idx_t'(2);
  localparam cfg_idx_t REG_ANG_ACCEL = cfg_idx_t'(3);
  localparam cfg_idx_t REG_ANG_DECEL = cfg_idx_t'(4);
  localparam cfg_idx_t REG_ANG_JERK  = cfg_idx_t'(5);

  // Register reset values.
  localparam limit_t LIN_ACCEL_RST = limit_t'(39322);
  localparam limit_t LIN_DECEL_RST = limit_t'(65536);
  localparam limit_t LIN_JERK_RST  = limit_t'(52429);
  localparam limit_t ANG_ACCEL_RST = limit_t'(98304);
  localparam limit_t ANG_DECEL_RST = limit_t'(163840);
  localparam limit_t ANG_JERK_RST  = limit_t'(131072);

  // Sequencer states: two multiplier passes for each axis.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_LJERK = 10'b00_0000_0010,
    S_LACC  = 10'b00_0000_0100,
    S_LVEL  = 10'b00_0000_1000,
    S_LFIN  = 10'b00_0001_0000,
    S_AJERK = 10'b00_0010_0000,
    S_AACC  = 10'b00_0100_0000,
    S_AVEL  = 10'b00_1000_0000,
    S_AFIN  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  // Saturate a value one bit wider than the field to the field range.
  function automatic value_t sat_value(input logic signed [VALUE_W:0] x);
    value_t res;
    if (x[VALUE_W] != x[VALUE_W-1]) begin
      res = x[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      res = x[VALUE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jlvr_in_if.sv =====
// ----------------------------------------------------------------------------
// jlvr_in_if: command channel of the velocity ramp
// One tick: target velocities, elapsed time and the clear flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jlvr_in_if import jlvr_pkg::*;;
  logic   valid;
  logic   ready;
  value_t lin_target;
  value_t ang_target;
  time_t  elapsed_time;
  logic   clear;

  modport source (output valid, lin_target, ang_target, elapsed_time, clear,
                  input ready);
  modport sink (input valid, lin_target, ang_target, elapsed_time, clear,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/jlvr_out_if.sv =====
// ----------------------------------------------------------------------------
// jlvr_out_if: result channel of the velocity ramp
// New velocity and acceleration of both axes after one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface jlvr_out_if import jlvr_pkg::*;;
  logic   valid;
  logic   ready;
  value_t linear_velocity;
  value_t angular_velocity;
  value_t linear_accel;
  value_t angular_accel;

  modport source (output valid, linear_velocity, angular_velocity, linear_accel,
                  angular_accel, input ready);
  modport sink (input valid, linear_velocity, angular_velocity, linear_accel,
                angular_accel, output ready);
endinterface

`default_nettype wire

// ===== hdl/jlvr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// jlvr_cfg_if: configuration write channel of the velocity ramp
// Carries a register index and the data to write.
// ----------------------------------------------------------------------------
`default_nettype none

interface jlvr_cfg_if import jlvr_pkg::*;;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/jerk_limited_velocity_ramp.sv =====
// ----------------------------------------------------------------------------
// jerk_limited_velocity_ramp: two-axis jerk-limited velocity smoother
// A small sequencer steps the linear axis, then the angular axis, through
// one shared multiplier and one shared block of axis arithmetic.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  cmd       in         lin_target, ang_target, elapsed_time, clear
//  result    out        linear_velocity, angular_velocity, linear_accel,
//                       angular_accel
//  cfg       in         index (0..5), data (23-bit limit)
//
//  A tick's result is registered once each axis has run through a jerk
//  pass, an acceleration step, a velocity pass and a finish step, the two
//  passes (jerk step, then velocity step) sharing the single multiplier,
//  and a load step has filled the result register. A clear tick goes
//  straight to the load step, with the axis state zeroed on acceptance.
//  The next tick is accepted as soon as the sequencer is back in idle, even
//  while a previous result still waits on a stalled result channel; a second
//  finished tick waits in the load step and the command side stays not ready.
//  Synchronous reset zeroes velocities and accelerations and loads the
//  limit registers with their defaults. Configuration writes are always ready.
//
`default_nettype none

module jerk_limited_velocity_ramp import jlvr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  jlvr_in_if.sink     cmd,
  jlvr_out_if.source  result,
  jlvr_cfg_if.sink    cfg
);

  state_t             state;
  state_t             state_next;
  limit_t             lin_accel_lim;
  limit_t             lin_decel_lim;
  limit_t             lin_jerk_lim;
  limit_t             ang_accel_lim;
  limit_t             ang_decel_lim;
  limit_t             ang_jerk_lim;
  value_t             lin_vel;
  value_t             lin_acc;
  value_t             ang_vel;
  value_t             ang_acc;
  value_t             tgt_lin;
  value_t             tgt_ang;
  time_t              dt;
  value_t             na_hold;
  logic               cmd_fire;
  logic               out_load;
  logic               sel_ang;
  logic               jerk_pass;
  value_t             vel_sel;
  value_t             acc_sel;
  value_t             tgt_sel;
  limit_t             accel_sel;
  limit_t             decel_sel;
  limit_t             jerk_sel;
  logic [VALUE_W-1:0] mul_a;
  prod_t              prod;
  value_t             na;
  logic [VALUE_W-1:0] na_mag;
  value_t             vel_new;
  value_t             acc_new;
  logic               snap;
  value_t             out_lin_vel;
  value_t             out_ang_vel;
  value_t             out_lin_acc;
  value_t             out_ang_acc;
  logic               out_valid;

  // Handshakes.
  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_load  = (state == S_DONE) && (!out_valid || result.ready);

  // Limit registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_accel_lim <= LIN_ACCEL_RST;
      lin_decel_lim <= LIN_DECEL_RST;
      lin_jerk_lim  <= LIN_JERK_RST;
      ang_accel_lim <= ANG_ACCEL_RST;
      ang_decel_lim <= ANG_DECEL_RST;
      ang_jerk_lim  <= ANG_JERK_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_LIN_ACCEL: lin_accel_lim <= cfg.data;
        REG_LIN_DECEL: lin_decel_lim <= cfg.data;
        REG_LIN_JERK:  lin_jerk_lim  <= cfg.data;
        REG_ANG_ACCEL: ang_accel_lim <= cfg.data;
        REG_ANG_DECEL: ang_decel_lim <= cfg.data;
        REG_ANG_JERK:  ang_jerk_lim  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd_fire) state_next = cmd.clear ? S_DONE : S_LJERK;
      S_LJERK: state_next = S_LACC;
      S_LACC:  state_next = S_LVEL;
      S_LVEL:  state_next = S_LFIN;
      S_LFIN:  state_next = S_AJERK;
      S_AJERK: state_next = S_AACC;
      S_AACC:  state_next = S_AVEL;
      S_AVEL:  state_next = S_AFIN;
      S_AFIN:  state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the tick's operands.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      tgt_lin <= cmd.lin_target;
      tgt_ang <= cmd.ang_target;
      dt      <= cmd.elapsed_time;
    end
  end

  // Axis selection for the shared arithmetic.
  always_comb begin
    sel_ang   = state inside {S_AJERK, S_AACC, S_AVEL, S_AFIN};
    jerk_pass = state inside {S_LJERK, S_AJERK};
    vel_sel   = sel_ang ? ang_vel : lin_vel;
    acc_sel   = sel_ang ? ang_acc : lin_acc;
    tgt_sel   = sel_ang ? tgt_ang : tgt_lin;
    accel_sel = sel_ang ? ang_accel_lim : lin_accel_lim;
    decel_sel = sel_ang ? ang_decel_lim : lin_decel_lim;
    jerk_sel  = sel_ang ? ang_jerk_lim : lin_jerk_lim;
    mul_a     = jerk_pass ? {1'b0, jerk_sel} : na_mag;
  end

  jlvr_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (dt),
    .prod (prod)
  );

  jlvr_axis_calc u_calc (
    .vel       (vel_sel),
    .acc       (acc_sel),
    .target    (tgt_sel),
    .accel_lim (accel_sel),
    .decel_lim (decel_sel),
    .prod      (prod),
    .na_hold   (na_hold),
    .na        (na),
    .na_mag    (na_mag),
    .vel_new   (vel_new),
    .acc_new   (acc_new),
    .snap      (snap)
  );

  // Hold the new acceleration between the two multiplier passes.
  always_ff @(posedge clk) begin
    if (state == S_LACC || state == S_AACC) begin
      na_hold <= na;
    end
  end

  // Axis state.
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_vel <= '0;
      lin_acc <= '0;
      ang_vel <= '0;
      ang_acc <= '0;
    end else if (cmd_fire && cmd.clear) begin
      lin_vel <= '0;
      lin_acc <= '0;
      ang_vel <= '0;
      ang_acc <= '0;
    end else if (state == S_LFIN) begin
      lin_vel <= vel_new;
      lin_acc <= acc_new;
    end else if (state == S_AFIN) begin
      ang_vel <= vel_new;
      ang_acc <= acc_new;
    end
  end

  // Result register; a waiting result does not block the next tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lin_vel <= lin_vel;
      out_ang_vel <= ang_vel;
      out_lin_acc <= lin_acc;
      out_ang_acc <= ang_acc;
    end
  end

  assign result.valid            = out_valid;
  assign result.linear_velocity  = out_lin_vel;
  assign result.angular_velocity = out_ang_vel;
  assign result.linear_accel     = out_lin_acc;
  assign result.angular_accel    = out_ang_acc;

  // A clear tick leaves both axes at rest.
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd.clear) |=>
      (lin_vel == '0 && lin_acc == '0 && ang_vel == '0 && ang_acc == '0))
    else $error("clear tick did not zero the axis state");

  // A normal tick starts with the linear jerk pass.
  a_tick_start: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && !cmd.clear) |=> (state == S_LJERK))
    else $error("tick did not start the linear axis");

  // Reaching the target pins the velocity to it and drops the acceleration.
  a_lin_snap: assert property (@(posedge clk) disable iff (rst)
    (state == S_LFIN && snap) |=> (lin_acc == '0 && lin_vel == tgt_lin))
    else $error("linear snap to target failed");

  // A loaded result shows the axis state that was just finished.
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (result.valid && result.linear_velocity == lin_vel &&
                  result.angular_accel == ang_acc))
    else $error("result register does not match axis state");

endmodule

`default_nettype wire

// ===== hdl/jlvr_mul.sv =====
// ----------------------------------------------------------------------------
// jlvr_mul: shared time-scaling multiplier
// Unsigned magnitude times elapsed time, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module jlvr_mul import jlvr_pkg::*; (
  input  logic               clk,
  input  logic [VALUE_W-1:0] op_a,
  input  time_t              op_b,
  output prod_t              prod
);

  // One 24 by 16 bit product per cycle.
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

`default_nettype wire

// ===== hdl/jlvr_axis_calc.sv =====
// ----------------------------------------------------------------------------
// jlvr_axis_calc: per-axis ramp arithmetic
// Works out the new acceleration from the jerk step, then the new velocity
// from the scaled acceleration, with the snap to the target.
// ----------------------------------------------------------------------------
`default_nettype none

module jlvr_axis_calc import jlvr_pkg::*; (
  input  value_t             vel,
  input  value_t             acc,
  input  value_t             target,
  input  limit_t             accel_lim,
  input  limit_t             decel_lim,
  input  prod_t              prod,
  input  value_t             na_hold,
  output value_t             na,
  output logic [VALUE_W-1:0] na_mag,
  output value_t             vel_new,
  output value_t             acc_new,
  output logic               snap
);

  logic signed [VALUE_W:0]   vel_x;
  logic signed [VALUE_W:0]   tgt_x;
  logic signed [VALUE_W:0]   diff;
  logic [VALUE_W-1:0]        vel_mag;
  logic [VALUE_W-1:0]        tgt_mag;
  logic                      vel_neg;
  logic                      vel_pos;
  logic                      tgt_neg;
  logic                      tgt_pos;
  logic                      decel;
  limit_t                    lim_mag;
  limit_t                    scaled;
  logic signed [VALUE_W+1:0] lim;
  logic signed [VALUE_W+1:0] step_x;
  logic signed [VALUE_W+1:0] acc_x;
  logic signed [VALUE_W+1:0] delta;
  logic signed [VALUE_W+1:0] delta_c;
  logic signed [VALUE_W+1:0] na_w;
  logic signed [VALUE_W:0]   scaled_x;
  logic signed [VALUE_W:0]   vel_step;
  logic signed [VALUE_W:0]   nv;

  // Difference to the target and the deceleration test.
  always_comb begin
    vel_x   = {vel[VALUE_W-1], vel};
    tgt_x   = {target[VALUE_W-1], target};
    diff    = tgt_x - vel_x;
    vel_mag = vel_x[VALUE_W] ? VALUE_W'(-vel_x) : VALUE_W'(vel_x);
    tgt_mag = tgt_x[VALUE_W] ? VALUE_W'(-tgt_x) : VALUE_W'(tgt_x);
    vel_neg = vel[VALUE_W-1];
    vel_pos = !vel[VALUE_W-1] && (|vel);
    tgt_neg = target[VALUE_W-1];
    tgt_pos = !target[VALUE_W-1] && (|target);
    decel   = (vel_neg && tgt_pos) || (vel_pos && tgt_neg) || (tgt_mag < vel_mag);
    lim_mag = decel ? decel_lim : accel_lim;
  end

  // New acceleration: move toward the signed limit by at most the jerk step.
  // The multiplier holds jerk times elapsed time in this phase.
  always_comb begin
    lim    = diff[VALUE_W] ? -$signed({3'b000, lim_mag}) : $signed({3'b000, lim_mag});
    step_x = $signed({3'b000, prod[TIME_FRAC+LIMIT_W-1:TIME_FRAC]});
    acc_x  = {{2{acc[VALUE_W-1]}}, acc};
    delta  = lim - acc_x;
    if (delta > step_x) begin
      delta_c = step_x;
    end else if (delta < -step_x) begin
      delta_c = -step_x;
    end else begin
      delta_c = delta;
    end
    na_w = acc_x + delta_c;
    na   = sat_value(na_w[VALUE_W:0]);
  end

  // Magnitude of the held acceleration, the multiplier operand of the next pass.
  assign na_mag = na_hold[VALUE_W-1] ? VALUE_W'(-{na_hold[VALUE_W-1], na_hold})
                                     : VALUE_W'(na_hold);

  // New velocity: the multiplier now holds |acceleration| times elapsed time,
  // truncated toward zero before the sign goes back on.
  always_comb begin
    scaled   = prod[TIME_FRAC+LIMIT_W-1:TIME_FRAC];
    scaled_x = $signed({2'b00, scaled});
    vel_step = na_hold[VALUE_W-1] ? -scaled_x : scaled_x;
    nv       = vel_x + vel_step;
    snap     = (diff == '0) ||
               (!diff[VALUE_W] && (nv >= tgt_x)) ||
               (diff[VALUE_W] && (nv <= tgt_x));
    vel_new  = snap ? target : sat_value(nv);
    acc_new  = snap ? value_t'(0) : na_hold;
  end

endmodule

`default_nettype wire

// ===== test/jlvr_motion_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jlvr_motion_checker: predicts and checks the velocity ramp results
// Watches the command, configuration and result channels, keeps its own copy
// of the limit registers and the per-axis motion state, and compares every
// result transfer, field by field, against the oldest predicted motion.
// ----------------------------------------------------------------------------

module jlvr_motion_checker import jlvr_pkg::*; (
  input  logic clk,
  input  logic rst,
  jlvr_in_if   cmd,
  jlvr_out_if  result,
  jlvr_cfg_if  cfg,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    value_t lin_vel;
    value_t ang_vel;
    value_t lin_acc;
    value_t ang_acc;
  } motion_t;

  limit_t  limit_reg [6];
  longint  v_lin, a_lin, v_ang, a_ang;
  motion_t pending_motion_q [$];
  int      fail_count = 0;
  int      queued_count = 0;

  assign errors      = fail_count;
  assign outstanding = queued_count;

  // Clip a wide intermediate to the signed field range.
  function automatic longint clip_to_field(input longint x);
    longint hi, lo;
    hi = (longint'(1) <<< (VALUE_W - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // One jerk-limited step of one axis: accel slews toward the signed limit,
  // velocity integrates the new accel, and crossing the target snaps to it.
  function automatic void advance_axis(inout longint vel, inout longint acc,
                                       input longint tgt, input longint up_lim,
                                       input longint down_lim, input longint jerk,
                                       input longint dt);
    longint diff, lim, jstep, dacc, nacc, nvel, mag;
    logic   braking;
    diff = tgt - vel;
    if (diff == 0) begin
      vel = tgt;
      acc = 0;
      return;
    end
    braking = (vel < 0 && tgt > 0) || (vel > 0 && tgt < 0) ||
              ((tgt < 0 ? -tgt : tgt) < (vel < 0 ? -vel : vel));
    lim = braking ? down_lim : up_lim;
    if (diff < 0) lim = -lim;
    jstep = (jerk * dt) >>> TIME_FRAC;
    dacc = lim - acc;
    if (dacc > jstep) dacc = jstep;
    if (dacc < -jstep) dacc = -jstep;
    nacc = acc + dacc;
    // Velocity change is truncated toward zero.
    mag = nacc < 0 ? -nacc : nacc;
    mag = (mag * dt) >>> TIME_FRAC;
    nvel = vel + (nacc < 0 ? -mag : mag);
    if ((diff > 0 && nvel >= tgt) || (diff < 0 && nvel <= tgt)) begin
      vel = tgt;
      acc = 0;
    end else begin
      vel = clip_to_field(nvel);
      acc = clip_to_field(nacc);
    end
  endfunction

  task automatic check_field(input string name, input value_t want, input value_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Observe all three channels at each rising edge.
  always @(posedge clk) begin : observe
    motion_t want, got;
    if (rst) begin
      limit_reg[REG_LIN_ACCEL] = LIN_ACCEL_RST;
      limit_reg[REG_LIN_DECEL] = LIN_DECEL_RST;
      limit_reg[REG_LIN_JERK]  = LIN_JERK_RST;
      limit_reg[REG_ANG_ACCEL] = ANG_ACCEL_RST;
      limit_reg[REG_ANG_DECEL] = ANG_DECEL_RST;
      limit_reg[REG_ANG_JERK]  = ANG_JERK_RST;
      v_lin = 0;
      a_lin = 0;
      v_ang = 0;
      a_ang = 0;
      pending_motion_q.delete();
    end else begin
      // Register writes; indexes past the last register are ignored.
      if (cfg.valid && cfg.ready && cfg.index <= REG_ANG_JERK) begin
        limit_reg[cfg.index] = cfg.data;
      end

      // Result transfer: compare against the oldest prediction.
      if (result.valid && result.ready) begin
        got.lin_vel = result.linear_velocity;
        got.ang_vel = result.angular_velocity;
        got.lin_acc = result.linear_accel;
        got.ang_acc = result.angular_accel;
        if (pending_motion_q.size() == 0) begin
          $error("result transfer with no prediction waiting: vel %0d/%0d acc %0d/%0d",
                 got.lin_vel, got.ang_vel, got.lin_acc, got.ang_acc);
          fail_count++;
        end else begin
          want = pending_motion_q.pop_front();
          check_field("linear_velocity", want.lin_vel, got.lin_vel);
          check_field("angular_velocity", want.ang_vel, got.ang_vel);
          check_field("linear_accel", want.lin_acc, got.lin_acc);
          check_field("angular_accel", want.ang_acc, got.ang_acc);
        end
      end

      // Command transfer: step the predicted state.
      if (cmd.valid && cmd.ready) begin
        if (cmd.clear) begin
          v_lin = 0;
          a_lin = 0;
          v_ang = 0;
          a_ang = 0;
        end else begin
          advance_axis(v_lin, a_lin, longint'(cmd.lin_target),
                       longint'(limit_reg[REG_LIN_ACCEL]), longint'(limit_reg[REG_LIN_DECEL]),
                       longint'(limit_reg[REG_LIN_JERK]), longint'(cmd.elapsed_time));
          advance_axis(v_ang, a_ang, longint'(cmd.ang_target),
                       longint'(limit_reg[REG_ANG_ACCEL]), longint'(limit_reg[REG_ANG_DECEL]),
                       longint'(limit_reg[REG_ANG_JERK]), longint'(cmd.elapsed_time));
        end
        want.lin_vel = value_t'(v_lin);
        want.ang_vel = value_t'(v_ang);
        want.lin_acc = value_t'(a_lin);
        want.ang_acc = value_t'(a_ang);
        pending_motion_q.push_back(want);
      end
    end
    queued_count <= pending_motion_q.size();
  end

endmodule

// ===== test/tb_jerk_limited_velocity_ramp.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jerk_limited_velocity_ramp: testbench of the jerk-limited velocity ramp
// Drives ticks through directed corner cases and then through several limit
// settings with random target holds, clears and noise, with random gaps on
// both channels and one long result stall. A separate checker predicts every
// result and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_jerk_limited_velocity_ramp;
  import jlvr_pkg::*;

  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          LONG_HOLD     = 300;
  localparam int          SETTLE_CYCLES = 24;
  localparam value_t      VEL_MAX       = value_t'(8388607);
  localparam value_t      VEL_MIN       = value_t'(-8388608);
  localparam limit_t      LIMIT_MAX     = limit_t'(8388607);
  localparam limit_t      LIMIT_MIN     = limit_t'(1);
  localparam cfg_idx_t    REG_SPARE_LO  = cfg_idx_t'(6);
  localparam cfg_idx_t    REG_SPARE_HI  = cfg_idx_t'(7);

  typedef enum int {MIX_RANDOM, MIX_MAX, MIX_MIN, MIX_ZERO} limit_mix_t;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   outstanding;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  logic hold_results = 1'b0;
  int   ticks_sent = 0;
  int   clears_sent = 0;
  int   settings_used = 1;
  int unsigned cycle_count = 0;

  jlvr_in_if  cmd_if ();
  jlvr_out_if res_if ();
  jlvr_cfg_if cfg_if ();

  jerk_limited_velocity_ramp DUT (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  jlvr_motion_checker motion_check (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_if),
    .result      (res_if),
    .cfg         (cfg_if),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Safety net against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Idle length: mostly a few cycles, now and then a long one.
  function automatic int idle_span();
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Targets are mostly small enough for the ramp to reach them.
  function automatic value_t pick_target();
    int r;
    r = $urandom_range(99);
    if (r < 45) return value_t'(int'($urandom_range(524288)) - 262144);
    if (r < 75) return value_t'(int'($urandom_range(4194304)) - 2097152);
    if (r < 79) return VEL_MAX;
    if (r < 83) return VEL_MIN;
    if (r < 86) return value_t'(0);
    return value_t'($urandom);
  endfunction

  function automatic time_t pick_dt();
    int r;
    r = $urandom_range(99);
    if (r < 60) return time_t'($urandom_range(65535, 4096));
    if (r < 85) return time_t'($urandom_range(4095, 1));
    if (r < 91) return time_t'(65535);
    if (r < 97) return time_t'(1);
    return time_t'(0);
  endfunction

  function automatic limit_t pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 40) return limit_t'($urandom_range(262144, 4096));
    if (r < 70) return limit_t'($urandom_range(4194304, 262145));
    if (r < 80) return LIMIT_MAX;
    if (r < 85) return LIMIT_MIN;
    return limit_t'($urandom);
  endfunction

  // One command transfer, after an optional random gap.
  task automatic send_tick(input value_t lin, input value_t ang, input time_t dt,
                           input logic clr);
    int gap;
    gap = ($urandom_range(99) < src_idle_pct) ? idle_span() : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.lin_target   <= lin;
    cmd_if.ang_target   <= ang;
    cmd_if.elapsed_time <= dt;
    cmd_if.clear        <= clr;
    do @(posedge clk); while (!cmd_if.ready);
    ticks_sent++;
    if (clr) clears_sent++;
  endtask

  // Holds the configuration valid high; the caller lowers it after the last write.
  task automatic load_limit(input cfg_idx_t idx, input limit_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Wait until every predicted result has been transferred.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic program_limits(input limit_mix_t mix);
    limit_t lim;
    for (int i = REG_LIN_ACCEL; i <= REG_ANG_JERK; i++) begin
      case (mix)
        MIX_MAX: lim = LIMIT_MAX;
        MIX_MIN: lim = LIMIT_MIN;
        // Frozen linear accel and an angular accel pulled toward zero.
        MIX_ZERO: lim = (i == REG_LIN_JERK || i == REG_ANG_ACCEL) ? limit_t'(0) : pick_limit();
        default: lim = pick_limit();
      endcase
      load_limit(cfg_idx_t'(i), lim);
    end
    if (mix == MIX_ZERO) begin
      load_limit(REG_SPARE_LO, LIMIT_MAX);
      load_limit(REG_SPARE_HI, limit_t'($urandom));
    end
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly held targets that the ramp can follow, some clears and some noise.
  task automatic run_phase(input limit_mix_t mix, input int count, input int src_pct,
                           input int snk_pct);
    int     stop_at, hold, r;
    value_t tl, ta;
    drain_results();
    program_limits(mix);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 80) begin
        tl = pick_target();
        ta = pick_target();
        hold = $urandom_range(40, 4);
        repeat (hold) send_tick(tl, ta, pick_dt(), 1'b0);
      end else if (r < 88) begin
        send_tick(pick_target(), pick_target(), pick_dt(), 1'b1);
      end else begin
        repeat ($urandom_range(5, 1)) begin
          send_tick(value_t'($urandom), value_t'($urandom), time_t'($urandom),
                    1'($urandom));
        end
      end
    end
  endtask

  // Result side pacing; a requested hold keeps ready low for a long stretch.
  initial begin : result_pacing
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(99) < snk_idle_pct) begin
        res_if.ready <= 1'b0;
        repeat (idle_span()) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    rst                 <= 1'b1;
    cmd_if.valid        <= 1'b0;
    cmd_if.lin_target   <= '0;
    cmd_if.ang_target   <= '0;
    cmd_if.elapsed_time <= '0;
    cmd_if.clear        <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_LIN_ACCEL;
    cfg_if.data         <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed corners with the reset limits.
    src_idle_pct = 30;
    snk_idle_pct = 30;
    send_tick(value_t'(0), value_t'(0), time_t'(65535), 1'b0);    // already on target
    send_tick(VEL_MAX, VEL_MIN, time_t'(65535), 1'b0);
    send_tick(VEL_MAX, VEL_MIN, time_t'(65535), 1'b0);
    send_tick(VEL_MIN, VEL_MAX, time_t'(65535), 1'b0);            // reversal brakes
    send_tick(VEL_MIN, VEL_MAX, time_t'(1), 1'b0);
    send_tick(VEL_MIN, VEL_MAX, time_t'(0), 1'b0);                // no time elapsed
    send_tick(value_t'(0), value_t'(0), time_t'(65535), 1'b1);
    send_tick(VEL_MAX, VEL_MIN, time_t'(0), 1'b1);                // clear ignores fields
    // Ramp to a small target until it snaps, then slow down and hold.
    repeat (8) send_tick(value_t'(65536), value_t'(-98304), time_t'(32768), 1'b0);
    repeat (3) send_tick(value_t'(32768), value_t'(-32768), time_t'(32768), 1'b0);
    send_tick(value_t'(32768), value_t'(-32768), time_t'(0), 1'b0);
    send_tick(value_t'(1), value_t'(-1), time_t'(65535), 1'b0);

    // Long result stall while ticks keep coming back to back.
    drain_results();
    src_idle_pct = 0;
    hold_results = 1'b1;
    repeat (20) send_tick(pick_target(), pick_target(), pick_dt(), 1'b0);

    // Random traffic over several limit settings.
    run_phase(MIX_RANDOM, 240, 0, 0);
    run_phase(MIX_MAX, 240, 30, 30);
    run_phase(MIX_MIN, 60, 30, 60);
    run_phase(MIX_ZERO, 120, 30, 30);
    run_phase(MIX_RANDOM, 240, 30, 30);
    run_phase(MIX_RANDOM, 240, 20, 50);
    run_phase(MIX_RANDOM, 240, 50, 20);
    run_phase(MIX_MAX, 200, 30, 30);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d ticks (%0d clears) under %0d limit settings,", ticks_sent,
             clears_sent, settings_used);
    $display("with random gaps on both channels and one long result stall.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jlvr_pkg.sv
hdl/jlvr_in_if.sv
hdl/jlvr_out_if.sv
hdl/jlvr_cfg_if.sv
hdl/jlvr_mul.sv
hdl/jlvr_axis_calc.sv
hdl/jerk_limited_velocity_ramp.sv
test/jlvr_motion_checker.sv
test/tb_jerk_limited_velocity_ramp.sv
